### rtl/mck_pkg.sv
package mck_pkg;

    localparam int UNIT_W     = 20;
    localparam int UNITS_W    = 3;
    localparam int DUR_W      = 23;
    localparam int CHAR_W     = 8;
    localparam int SEG_CNT_W  = 4;
    localparam int SYM_CNT_W  = 3;
    localparam int PAT_W      = 5;
    localparam int TAB_IDX_W  = 6;
    localparam int BIT_CNT_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    localparam logic [UNIT_W-1:0]  UNIT_RESET     = 20'd100000;
    localparam logic [UNITS_W-1:0] DOT_UNITS      = 3'd1;
    localparam logic [UNITS_W-1:0] DASH_UNITS     = 3'd2;
    localparam logic [UNITS_W-1:0] SYM_GAP_UNITS  = 3'd1;
    localparam logic [UNITS_W-1:0] CHAR_GAP_UNITS = 3'd3;
    localparam logic [UNITS_W-1:0] WORD_GAP_UNITS = 3'd7;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;
    localparam logic [TAB_IDX_W-1:0] DIGIT_BASE = 6'd26;

    typedef struct packed {
        logic [SYM_CNT_W-1:0] len;
        logic [PAT_W-1:0]     pat;
    } morse_code_t;

    // Bit s of the pattern is symbol s of the character, 1 for a dash.
    function automatic morse_code_t morse_lookup(input logic [TAB_IDX_W-1:0] idx);
        morse_code_t r;
        case (idx)
            6'd0:  r = '{3'd2, 5'b00010};
            6'd1:  r = '{3'd4, 5'b00001};
            6'd2:  r = '{3'd4, 5'b00101};
            6'd3:  r = '{3'd3, 5'b00001};
            6'd4:  r = '{3'd1, 5'b00000};
            6'd5:  r = '{3'd4, 5'b00100};
            6'd6:  r = '{3'd3, 5'b00011};
            6'd7:  r = '{3'd4, 5'b00000};
            6'd8:  r = '{3'd2, 5'b00000};
            6'd9:  r = '{3'd4, 5'b01110};
            6'd10: r = '{3'd3, 5'b00101};
            6'd11: r = '{3'd4, 5'b00010};
            6'd12: r = '{3'd2, 5'b00011};
            6'd13: r = '{3'd2, 5'b00001};
            6'd14: r = '{3'd3, 5'b00111};
            6'd15: r = '{3'd4, 5'b00110};
            6'd16: r = '{3'd4, 5'b01011};
            6'd17: r = '{3'd3, 5'b00010};
            6'd18: r = '{3'd3, 5'b00000};
            6'd19: r = '{3'd1, 5'b00001};
            6'd20: r = '{3'd3, 5'b00100};
            6'd21: r = '{3'd4, 5'b01000};
            6'd22: r = '{3'd3, 5'b00110};
            6'd23: r = '{3'd4, 5'b01001};
            6'd24: r = '{3'd4, 5'b01101};
            6'd25: r = '{3'd4, 5'b00011};
            6'd26: r = '{3'd5, 5'b11111};
            6'd27: r = '{3'd5, 5'b11110};
            6'd28: r = '{3'd5, 5'b11100};
            6'd29: r = '{3'd5, 5'b11000};
            6'd30: r = '{3'd5, 5'b10000};
            6'd31: r = '{3'd5, 5'b00000};
            6'd32: r = '{3'd5, 5'b00001};
            6'd33: r = '{3'd5, 5'b00011};
            6'd34: r = '{3'd5, 5'b00111};
            6'd35: r = '{3'd5, 5'b01111};
            default: r = '{3'd1, 5'b00000};
        endcase
        return r;
    endfunction

endpackage

### rtl/morse_character_keyer_core.sv
// Channel   | Ports          | Contents
// ----------+----------------+-------------------------------------------------
// input     | s_axis_*       | one character byte per request
// output    | m_axis_*       | one key segment per request, tlast on the final one
// config    | cfg_wr_*       | unit length in microseconds
//
// Each segment is selected, then formed in three steps of the shared shift-add unit as
// units times unit_us, and then held out until it is taken.
// A character of n symbols gives 2n segments. A space or a slash gives a single word-gap
// segment, and any other byte that is not a letter or a digit is dropped with no segment.
// A new byte is taken only once the last segment of the previous one has been taken.
// Reset returns the sequencer to idle and loads the default unit of 100000 us.
// A stalled output holds the segment and the sequencer until it is taken.
module morse_character_keyer_core
    import mck_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [UNIT_W-1:0]     cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [0] led_on, [3:1] length_units,
                                                  // [26:4] duration_us
    output logic                  m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEG  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(UNITS_W - 1);

    logic [1:0]           state_reg,   state_next;
    logic [UNIT_W-1:0]    unit_reg,    unit_next;
    logic                 space_reg,   space_next;
    logic [SYM_CNT_W-1:0] len_reg,     len_next;
    logic [PAT_W-1:0]     pat_reg,     pat_next;
    logic [SEG_CNT_W-1:0] seg_reg,     seg_next;
    logic [BIT_CNT_W-1:0] bit_reg,     bit_next;
    logic                 led_reg,     led_next;
    logic [UNITS_W-1:0]   units_reg,   units_next;
    logic                 last_reg,    last_next;
    logic [DUR_W-1:0]     acc_reg,     acc_next;

    logic [CHAR_W-1:0]    char_fold;
    logic                 is_letter;
    logic                 is_digit;
    logic [TAB_IDX_W-1:0] tab_idx;
    morse_code_t          code;
    logic [SEG_CNT_W-1:0] seg_end;
    logic                 seg_is_last;
    logic [DUR_W-1:0]     addend;

    always_comb begin
        char_fold = s_axis_tdata;
        if (s_axis_tdata inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
            char_fold = s_axis_tdata - CASE_FOLD;
        end
        is_letter = char_fold inside {[CHAR_UC_A:CHAR_UC_Z]};
        is_digit  = char_fold inside {[CHAR_ZERO:CHAR_NINE]};
        if (is_digit) begin
            tab_idx = TAB_IDX_W'(char_fold - CHAR_ZERO) + DIGIT_BASE;
        end else begin
            tab_idx = TAB_IDX_W'(char_fold - CHAR_UC_A);
        end
        code = morse_lookup(tab_idx);
    end

    assign seg_end     = {len_reg, 1'b0} - SEG_CNT_W'(1);
    assign seg_is_last = (seg_reg == seg_end);
    assign addend      = units_reg[bit_reg] ? (DUR_W'(unit_reg) << bit_reg) : '0;

    always_comb begin
        state_next = state_reg;
        unit_next  = unit_reg;
        space_next = space_reg;
        len_next   = len_reg;
        pat_next   = pat_reg;
        seg_next   = seg_reg;
        bit_next   = bit_reg;
        led_next   = led_reg;
        units_next = units_reg;
        last_next  = last_reg;
        acc_next   = acc_reg;

        if (cfg_wr_en) begin
            unit_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    seg_next = '0;
                    if (s_axis_tdata == CHAR_SPACE || s_axis_tdata == CHAR_SLASH) begin
                        space_next = 1'b1;
                        state_next = ST_SEG;
                    end else if (is_letter || is_digit) begin
                        space_next = 1'b0;
                        len_next   = code.len;
                        pat_next   = code.pat;
                        state_next = ST_SEG;
                    end
                end
            end
            ST_SEG: begin
                if (space_reg) begin
                    led_next   = 1'b0;
                    units_next = WORD_GAP_UNITS;
                    last_next  = 1'b1;
                end else if (!seg_reg[0]) begin
                    led_next   = 1'b1;
                    units_next = pat_reg[seg_reg[SEG_CNT_W-1:1]] ? DASH_UNITS : DOT_UNITS;
                    last_next  = 1'b0;
                end else begin
                    led_next   = 1'b0;
                    units_next = seg_is_last ? CHAR_GAP_UNITS : SYM_GAP_UNITS;
                    last_next  = seg_is_last;
                end
                acc_next   = '0;
                bit_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next = acc_reg + addend;
                bit_next = bit_reg + BIT_CNT_W'(1);
                if (bit_reg == BIT_LAST) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_axis_tready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        seg_next   = seg_reg + SEG_CNT_W'(1);
                        state_next = ST_SEG;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            unit_reg  <= UNIT_RESET;
        end else begin
            state_reg <= state_next;
            unit_reg  <= unit_next;
        end
    end

    always_ff @(posedge aclk) begin
        space_reg <= space_next;
        len_reg   <= len_next;
        pat_reg   <= pat_next;
        seg_reg   <= seg_next;
        bit_reg   <= bit_next;
        led_reg   <= led_next;
        units_reg <= units_next;
        last_reg  <= last_next;
        acc_reg   <= acc_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_SEND);
    assign m_axis_tdata  = {(M_TDATA_W - DUR_W - UNITS_W - 1)'(0), acc_reg, units_reg, led_reg};
    assign m_axis_tlast  = last_reg;

endmodule

### test/tb_morse_character_keyer_core.sv
module tb_morse_character_keyer_core
    import mck_pkg::*;
();

    typedef struct packed {
        logic               led;
        logic [UNITS_W-1:0] units;
        logic [DUR_W-1:0]   dur;
        logic               last;
    } seg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              use_model;
        logic [1:0]        n_fixed;
        seg_t              fix0;
        seg_t              fix1;
    } char_row_t;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int DIR_ROWS = 25;

    localparam seg_t SEG_NONE  = '0;
    localparam seg_t SEG_WORD  = '{1'b0, 3'd7, 23'd700000, 1'b1};
    localparam seg_t SEG_DOT   = '{1'b1, 3'd1, 23'd100000, 1'b0};
    localparam seg_t SEG_DASH  = '{1'b1, 3'd2, 23'd200000, 1'b0};
    localparam seg_t SEG_CGAP  = '{1'b0, 3'd3, 23'd300000, 1'b1};

    // Rows without use_model carry their segments for the reset unit of 100000 us.
    localparam char_row_t DIR_TAB [DIR_ROWS] = '{
        '{8'h20, 1'b0, 2'd1, SEG_WORD, SEG_NONE},
        '{8'h2F, 1'b0, 2'd1, SEG_WORD, SEG_NONE},
        '{8'h45, 1'b0, 2'd2, SEG_DOT,  SEG_CGAP},
        '{8'h65, 1'b0, 2'd2, SEG_DOT,  SEG_CGAP},
        '{8'h54, 1'b0, 2'd2, SEG_DASH, SEG_CGAP},
        '{8'h74, 1'b0, 2'd2, SEG_DASH, SEG_CGAP},
        '{8'h00, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'hFF, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h40, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h5B, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h60, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h7B, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h2E, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h3A, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h21, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h80, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'hC1, 1'b0, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h41, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h5A, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h61, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h7A, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h30, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h39, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h35, 1'b1, 2'd0, SEG_NONE, SEG_NONE},
        '{8'h51, 1'b1, 2'd0, SEG_NONE, SEG_NONE}
    };

    string morse_tab [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [UNIT_W-1:0]    cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    logic [UNIT_W-1:0] unit_model = UNIT_RESET;
    seg_t              key_segs_due [$];
    char_row_t         chars_offered [$];
    int                mismatch_cnt = 0;
    int                idle_cycles = 0;
    bit                src_rush = 1'b0;
    bit                snk_rush = 1'b0;
    bit                long_hold_req = 1'b0;

    morse_character_keyer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic seg_t make_seg(input logic led, input logic [UNITS_W-1:0] units,
                                      input logic last);
        seg_t s;
        s.led = led;
        s.units = units;
        s.dur = {{(DUR_W-UNITS_W){1'b0}}, units} * {{(DUR_W-UNIT_W){1'b0}}, unit_model};
        s.last = last;
        return s;
    endfunction

    function automatic void encode_char(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        int idx;
        string pat;
        c = code;
        if (c == CHAR_SPACE || c == CHAR_SLASH) begin
            key_segs_due.push_back(make_seg(1'b0, WORD_GAP_UNITS, 1'b1));
            return;
        end
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            c = c - CASE_FOLD;
        end
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            idx = int'(c - CHAR_UC_A);
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            idx = int'(c - CHAR_ZERO) + int'(DIGIT_BASE);
        end else begin
            return;
        end
        pat = morse_tab[idx];
        for (int s = 0; s < pat.len(); s++) begin
            key_segs_due.push_back(make_seg(1'b1, (pat[s] == "-") ? DASH_UNITS : DOT_UNITS,
                                            1'b0));
            if (s + 1 < pat.len()) begin
                key_segs_due.push_back(make_seg(1'b0, SYM_GAP_UNITS, 1'b0));
            end
        end
        key_segs_due.push_back(make_seg(1'b0, CHAR_GAP_UNITS, 1'b1));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CHAR_UC_A + CHAR_W'($urandom_range(0, 25));
            3, 4:    return CHAR_LC_A + CHAR_W'($urandom_range(0, 25));
            5, 6:    return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
            7:       return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_SLASH;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge aclk) begin : monitor
        char_row_t row;
        seg_t got;
        seg_t want;
        if (!aresetn) begin
            unit_model = UNIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                unit_model = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                row = chars_offered.pop_front();
                if (row.use_model) begin
                    encode_char(row.code);
                end else begin
                    if (row.n_fixed > 0) key_segs_due.push_back(row.fix0);
                    if (row.n_fixed > 1) key_segs_due.push_back(row.fix1);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[26:4], m_axis_tlast};
                if (key_segs_due.size() == 0) begin
                    $display("%0t: unexpected segment led=%0d units=%0d dur=%0d last=%0d",
                             $time, got.led, got.units, got.dur, got.last);
                    mismatch_cnt++;
                end else begin
                    want = key_segs_due.pop_front();
                    if (got !== want || m_axis_tdata[M_TDATA_W-1:27] !== '0) begin
                        $write("%0t: expected led=%0d units=%0d dur=%0d last=%0d, ",
                               $time, want.led, want.units, want.dur, want.last);
                        $display("got led=%0d units=%0d dur=%0d last=%0d pad=%0h",
                                 got.led, got.units, got.dur, got.last,
                                 m_axis_tdata[M_TDATA_W-1:27]);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : segment_sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = snk_rush ? 0 : $urandom_range(0, 11);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
        end
    end

    task automatic offer_char(input char_row_t row);
        int gap;
        gap = src_rush ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        chars_offered.push_back(row);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= row.code;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drain_segments();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk);
        while (chars_offered.size() != 0 || key_segs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        char_row_t row;
        logic [UNIT_W-1:0] unit_val;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIR_TAB[i]) begin
            offer_char(DIR_TAB[i]);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_segments();
            case (ph)
                0:       unit_val = 20'd1;
                1:       unit_val = 20'hFFFFF;
                2:       unit_val = 20'd0;
                3:       unit_val = 20'd1000000;
                4:       unit_val = UNIT_W'($urandom_range(1, 1000000));
                default: unit_val = UNIT_W'($urandom_range(0, 20'hFFFFF));
            endcase
            write_unit(unit_val);
            src_rush = (ph <= 1);
            snk_rush = (ph == 0);
            // The sink stalls for a long stretch while requests keep coming.
            if (ph == 1) long_hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                row = '{pick_char(), 1'b1, 2'd0, SEG_NONE, SEG_NONE};
                offer_char(row);
            end
        end
        drain_segments();
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
